// ===== hdl/radix_tree_key_map_top_assert.svh =====
// assertion macros for the radix tree key map
`ifndef RADIX_TREE_KEY_MAP_TOP_ASSERT_SVH
`define RADIX_TREE_KEY_MAP_TOP_ASSERT_SVH

// same-cycle implication check
`define RTKM_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication check
`define RTKM_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== hdl/rtkm_pkg.sv =====
// shared types and codes for the radix tree key map
package rtkm_pkg;

  localparam int LEVEL_BITS_DEF = 4;
  localparam int LEVELS_DEF     = 4;
  localparam int NODES_DEF      = 256;

  // request codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] key;
    logic [31:0] value;
  } rtkm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
  } rtkm_out_t;

  // node pool requests
  typedef struct packed {
    logic pop;
    logic push;
  } rtkm_pool_req_t;

endpackage

// ===== hdl/rtkm_ram.sv =====
// generic single write port ram with registered read
module rtkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and held registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rtkm_pool.sv =====
// free node stack with fill-count initialization
module rtkm_pool import rtkm_pkg::*; #(
  parameter int NODES = NODES_DEF,
  localparam int NW = $clog2(NODES)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rtkm_pool_req_t req,
  input  logic [NW-1:0]  push_node,
  output logic [NW:0]    count,
  output logic [NW-1:0]  pop_node
);

  logic [NW:0]   fc_r, fc_nxt;
  logic [NW:0]   min_r, min_nxt;
  logic          init_sel_r;
  logic [NW-1:0] init_val_r;
  logic [NW:0]   top_idx;
  logic [NW-1:0] ram_q;
  logic          push_ok;

  assign top_idx = fc_r - 1'b1;
  assign push_ok = req.push && (fc_r < (NW+1)'(NODES));
  assign count   = fc_r;

  // entries below the low mark were never written; a pop there returns NODES-1 minus the index
  always_comb begin
    fc_nxt  = fc_r;
    min_nxt = min_r;
    if (req.pop) begin
      fc_nxt = top_idx;
      if (top_idx < min_r) begin
        min_nxt = top_idx;
      end
    end else if (push_ok) begin
      fc_nxt = fc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r  <= (NW+1)'(NODES);
      min_r <= (NW+1)'(NODES);
    end else begin
      fc_r  <= fc_nxt;
      min_r <= min_nxt;
    end
  end

  // pop side selection data
  always_ff @(posedge clk) begin
    if (req.pop) begin
      init_sel_r <= top_idx < min_r;
      init_val_r <= NW'(NODES - 1) - top_idx[NW-1:0];
    end
  end

  rtkm_ram #(.WIDTH(NW), .DEPTH(2**NW)) u_stack (
    .clk   (clk),
    .we    (push_ok),
    .waddr (fc_r[NW-1:0]),
    .wdata (push_node),
    .re    (req.pop),
    .raddr (top_idx[NW-1:0]),
    .rdata (ram_q)
  );

  assign pop_node = init_sel_r ? init_val_r : ram_q;

endmodule

// ===== hdl/radix_tree_key_map_top.sv =====
// radix tree key map top level with walk sequencer
// One item at a time: busy stays high from the accepted start until the
// result strobe, unless the item is answered straight from idle. Each level
// of the walk is a slot read, then a check, through the shared node
// memories; creating a missing node adds a pool pop, a link and a clear of
// the new node's slot mask. Misses on an empty tree, and inserts into an
// empty tree with no free node, are answered straight from idle.
// The result sits on out_item for one cycle with out_valid and cannot be held
// off, and busy is low again in that same cycle. No clearing pass after reset.
`include "radix_tree_key_map_top_assert.svh"
module radix_tree_key_map_top import rtkm_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int LEVELS     = LEVELS_DEF,
  parameter int NODES      = NODES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rtkm_in_t  in_item,
  output logic      out_valid,
  output rtkm_out_t out_item
);

  localparam int TOT    = LEVEL_BITS * LEVELS;
  localparam int FANOUT = 1 << LEVEL_BITS;
  localparam int NW     = $clog2(NODES);
  localparam int LVW    = $clog2(LEVELS + 1);
  localparam int CAW    = NW + LEVEL_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_POP  = 4'd3;
  localparam logic [3:0] S_LINK = 4'd4;
  localparam logic [3:0] S_CLR  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_LOUT = 4'd7;

  logic [3:0]            state_r, state_nxt;
  logic [1:0]            func_r, func_nxt;
  logic [TOT-1:0]        key_r, key_nxt;
  logic [31:0]           value_r, value_nxt;
  logic [NW-1:0]         node_r, node_nxt;
  logic [NW-1:0]         parent_r, parent_nxt;
  logic [LEVEL_BITS-1:0] digit_r, digit_nxt;
  logic [LVW-1:0]        lv_r, lv_nxt;
  logic [NW-1:0]         root_r, root_nxt;
  logic                  root_ok_r, root_ok_nxt;
  logic                  alloc_root_r, alloc_root_nxt;
  logic [NW-1:0]         newn_r, newn_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rtkm_out_t             out_r, out_nxt;

  logic [TOT-1:0]        key_ext;
  logic [LEVEL_BITS-1:0] digit;
  logic                  last_lv;

  logic                  mask_we, mask_re;
  logic [NW-1:0]         mask_wa;
  logic [FANOUT-1:0]     mask_wd, mask_q;
  logic                  child_we, child_re;
  logic [NW-1:0]         child_q;
  logic                  leaf_we, leaf_re;
  logic [31:0]           leaf_wd, leaf_q;
  rtkm_pool_req_t        pool_req;
  logic [NW:0]           pool_count;
  logic [NW-1:0]         pop_node;

  // key digits used, top digit first
  generate
    if (TOT >= 16) begin : g_key_wide
      assign key_ext = TOT'(in_item.key);
    end else begin : g_key_narrow
      assign key_ext = in_item.key[TOT-1:0];
    end
  endgenerate

  assign digit   = key_r[TOT-1 -: LEVEL_BITS];
  assign last_lv = (lv_r == LVW'(LEVELS - 1));

  // walk sequencer
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    node_nxt       = node_r;
    parent_nxt     = parent_r;
    digit_nxt      = digit_r;
    lv_nxt         = lv_r;
    root_nxt       = root_r;
    root_ok_nxt    = root_ok_r;
    alloc_root_nxt = alloc_root_r;
    newn_nxt       = newn_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    mask_we        = 1'b0;
    mask_re        = 1'b0;
    mask_wa        = node_r;
    mask_wd        = '0;
    child_we       = 1'b0;
    child_re       = 1'b0;
    leaf_we        = 1'b0;
    leaf_re        = 1'b0;
    leaf_wd        = value_r;
    pool_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = in_item.func;
          key_nxt   = key_ext;
          value_nxt = in_item.value;
          node_nxt  = root_r;
          lv_nxt    = '0;
          case (in_item.func)
            FUNC_INSERT: begin
              if (root_ok_r) begin
                state_nxt = S_RD;
              end else if (pool_count == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{status: ST_FULL, found_value: 32'd0};
              end else begin
                alloc_root_nxt = 1'b1;
                state_nxt      = S_POP;
              end
            end
            FUNC_LOOKUP, FUNC_DELETE: begin
              if (root_ok_r) begin
                state_nxt = S_RD;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{status: ST_MISSING, found_value: 32'd0};
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{status: ST_OK, found_value: 32'd0};
            end
          endcase
        end
      end
      S_RD: begin
        mask_re   = 1'b1;
        child_re  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (mask_q[digit]) begin
          // descend to the existing child
          parent_nxt = node_r;
          digit_nxt  = digit;
          node_nxt   = child_q;
          key_nxt    = key_r << LEVEL_BITS;
          lv_nxt     = lv_r + 1'b1;
          state_nxt  = last_lv ? S_FIN : S_RD;
        end else if (func_r != FUNC_INSERT) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_MISSING, found_value: 32'd0};
          state_nxt     = S_IDLE;
        end else if (pool_count == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ST_FULL, found_value: 32'd0};
          state_nxt     = S_IDLE;
        end else begin
          alloc_root_nxt = 1'b0;
          state_nxt      = S_POP;
        end
      end
      S_POP: begin
        pool_req.pop = 1'b1;
        state_nxt    = S_LINK;
      end
      S_LINK: begin
        // hook the new node under its parent, or make it the root
        newn_nxt = pop_node;
        if (alloc_root_r) begin
          root_nxt    = pop_node;
          root_ok_nxt = 1'b1;
        end else begin
          child_we = 1'b1;
          mask_we  = 1'b1;
          mask_wa  = node_r;
          mask_wd  = mask_q | (FANOUT'(1) << digit);
        end
        state_nxt = S_CLR;
      end
      S_CLR: begin
        mask_we  = 1'b1;
        mask_wa  = newn_r;
        mask_wd  = '0;
        node_nxt = newn_r;
        if (alloc_root_r) begin
          state_nxt = S_RD;
        end else begin
          parent_nxt = node_r;
          digit_nxt  = digit;
          key_nxt    = key_r << LEVEL_BITS;
          lv_nxt     = lv_r + 1'b1;
          state_nxt  = last_lv ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: ST_OK, found_value: 32'd0};
        case (func_r)
          FUNC_INSERT: begin
            leaf_we = 1'b1;
            leaf_wd = value_r;
          end
          FUNC_LOOKUP: begin
            leaf_re       = 1'b1;
            out_valid_nxt = 1'b0;
            state_nxt     = S_LOUT;
          end
          FUNC_DELETE: begin
            // free the leaf and drop its slot in the parent
            leaf_we       = 1'b1;
            leaf_wd       = 32'd0;
            mask_we       = 1'b1;
            mask_wa       = parent_r;
            mask_wd       = mask_q & ~(FANOUT'(1) << digit_r);
            pool_req.push = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_LOUT: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: ST_OK, found_value: leaf_q};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      root_ok_r    <= 1'b0;
      root_r       <= '0;
      alloc_root_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      root_ok_r    <= root_ok_nxt;
      root_r       <= root_nxt;
      alloc_root_r <= alloc_root_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // walk payload registers
  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    value_r  <= value_nxt;
    node_r   <= node_nxt;
    parent_r <= parent_nxt;
    digit_r  <= digit_nxt;
    lv_r     <= lv_nxt;
    newn_r   <= newn_nxt;
    out_r    <= out_nxt;
  end

  // per-node child valid masks
  rtkm_ram #(.WIDTH(FANOUT), .DEPTH(2**NW)) u_mask (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_wa),
    .wdata (mask_wd),
    .re    (mask_re),
    .raddr (node_r),
    .rdata (mask_q)
  );

  // child node indexes
  rtkm_ram #(.WIDTH(NW), .DEPTH(2**CAW)) u_child (
    .clk   (clk),
    .we    (child_we),
    .waddr ({node_r, digit}),
    .wdata (pop_node),
    .re    (child_re),
    .raddr ({node_r, digit}),
    .rdata (child_q)
  );

  // leaf values
  rtkm_ram #(.WIDTH(32), .DEPTH(2**NW)) u_leaf (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (node_r),
    .wdata (leaf_wd),
    .re    (leaf_re),
    .raddr (node_r),
    .rdata (leaf_q)
  );

  rtkm_pool #(.NODES(NODES)) u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (pool_req),
    .push_node (node_r),
    .count     (pool_count),
    .pop_node  (pop_node)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  `RTKM_ASSERT_NEXT(a_accept_busy, start && !busy, busy || out_valid,
                    "accepted item neither busy nor answered")
  `RTKM_ASSERT_NOW(a_result_after_work, out_valid, $past(busy || start),
                   "result without work")
  `RTKM_ASSERT_NOW(a_full_only_insert, out_valid && out_item.status == ST_FULL,
                   func_r == FUNC_INSERT, "pool full on non insert")
  `RTKM_ASSERT_NOW(a_value_only_lookup, out_valid && out_item.found_value != 32'd0,
                   func_r == FUNC_LOOKUP && out_item.status == ST_OK,
                   "value on non lookup")

endmodule
